// File: sv/pqed_pkg.sv
// ----------------------------------------------------------------------------
// pqed_pkg
// Shared constants, types and arithmetic helpers of the palette quantizer
// with error diffusion.
// ----------------------------------------------------------------------------
package pqed_pkg;

    localparam int PALETTE_DEPTH  = 32;
    localparam int PAL_AW         = $clog2(PALETTE_DEPTH);
    localparam int MAX_LINE_WIDTH = 512;
    localparam int COL_AW         = $clog2(MAX_LINE_WIDTH);
    localparam int MAX_ROWS       = 4096;
    localparam int DIST_W         = 18;

    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PALETTE_SIZE = 2'd2;
    localparam logic [1:0] CFG_DITHER       = 2'd3;

    typedef logic signed [9:0] err_t;

    typedef struct packed {
        err_t r;
        err_t g;
        err_t b;
    } err_rgb_t;

    typedef struct packed {
        logic pal_wr;
        logic pix_take;
        logic val_load;
        logic search_start;
        logic commit;
        logic finish;
    } pqed_cmd_t;

    typedef struct packed {
        logic search_busy;
        logic out_free;
    } pqed_sts_t;

    // Weighted share (e * wt) / 16, truncated toward zero.
    function automatic err_t share(input err_t e, input logic [3:0] wt);
        logic signed [14:0] p;
        logic signed [14:0] q;
        p = 15'(e) * $signed({11'b0, wt});
        q = p[14] ? p + 15'sd15 : p;
        return err_t'(q >>> 4);
    endfunction

    function automatic err_rgb_t rgb_share(input err_rgb_t e, input logic [3:0] wt,
                                           input logic en);
        err_rgb_t s;
        s.r = en ? share(e.r, wt) : '0;
        s.g = en ? share(e.g, wt) : '0;
        s.b = en ? share(e.b, wt) : '0;
        return s;
    endfunction

    function automatic err_rgb_t rgb_add(input err_rgb_t a, input err_rgb_t b);
        err_rgb_t s;
        s.r = a.r + b.r;
        s.g = a.g + b.g;
        s.b = a.b + b.b;
        return s;
    endfunction

    // Difference between a clamped pixel and a palette color, both {r,g,b}.
    function automatic err_rgb_t rgb_err(input logic [23:0] v, input logic [23:0] p);
        err_rgb_t e;
        e.r = err_t'($signed({2'b00, v[23:16]}) - $signed({2'b00, p[23:16]}));
        e.g = err_t'($signed({2'b00, v[15:8]})  - $signed({2'b00, p[15:8]}));
        e.b = err_t'($signed({2'b00, v[7:0]})   - $signed({2'b00, p[7:0]}));
        return e;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    function automatic logic [15:0] sq9(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = 18'(d) * 18'(d);
        return p[15:0];
    endfunction

endpackage

// File: sv/pqed_ctrl.sv
// ----------------------------------------------------------------------------
// pqed_ctrl
// Sequencer: takes one transaction at a time and steps a pixel through error
// fetch, clamp, palette search, error commit and counter update.
// ----------------------------------------------------------------------------
module pqed_ctrl
    import pqed_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_opcode,
    output logic      s_ready,
    input  pqed_sts_t sts,
    output pqed_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLAMP  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode) begin
                        cmd.pix_take = 1'b1;
                        state_next   = ST_CLAMP;
                    end else begin
                        cmd.pal_wr = 1'b1;
                    end
                end
            end
            ST_CLAMP: begin
                cmd.val_load     = 1'b1;
                cmd.search_start = 1'b1;
                state_next       = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (!sts.search_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/pqed_datapath.sv
// ----------------------------------------------------------------------------
// pqed_datapath
// Configuration registers, palette memory, pipelined nearest-color search,
// error line memory with diffusion window, and the output register.
// ----------------------------------------------------------------------------
module pqed_datapath
    import pqed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pqed_cmd_t   cmd,
    output pqed_sts_t   sts,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [4:0]  s_entry_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_color_index,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out
);

    // Configuration.
    logic [9:0]  lw_reg;
    logic [12:0] fh_reg;
    logic [5:0]  ps_reg;
    logic        de_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= 10'd256;
            fh_reg <= 13'd256;
            ps_reg <= 6'd32;
            de_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LINE_WIDTH:   lw_reg <= cfg_data[9:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                CFG_PALETTE_SIZE: ps_reg <= cfg_data[5:0];
                CFG_DITHER:       de_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective limits and position flags.
    logic [9:0]  w_eff;
    logic [12:0] h_eff;
    logic [5:0]  n_eff;
    logic        last_col;
    logic        last_row;
    logic [COL_AW-1:0] col_reg;
    logic [11:0] row_reg;
    logic [9:0]  fill_reg;

    always_comb begin
        if (lw_reg == '0) begin
            w_eff = 10'd1;
        end else if (int'(lw_reg) > MAX_LINE_WIDTH) begin
            w_eff = 10'(MAX_LINE_WIDTH);
        end else begin
            w_eff = lw_reg;
        end
        if (fh_reg == '0) begin
            h_eff = 13'd1;
        end else if (int'(fh_reg) > MAX_ROWS) begin
            h_eff = 13'(MAX_ROWS);
        end else begin
            h_eff = fh_reg;
        end
        // An empty palette still reads entry zero, which then wins.
        if (ps_reg == '0) begin
            n_eff = 6'd1;
        end else if (int'(ps_reg) > PALETTE_DEPTH) begin
            n_eff = 6'(PALETTE_DEPTH);
        end else begin
            n_eff = ps_reg;
        end
    end

    assign last_col = (10'(col_reg) + 10'd1) >= w_eff;
    assign last_row = (13'(row_reg) + 13'd1) >= h_eff;

    // Pixel capture and error fetch.
    logic [7:0] pix_r_reg, pix_g_reg, pix_b_reg;
    err_rgb_t   err_mem [MAX_LINE_WIDTH];
    err_rgb_t   err_q_reg;
    logic       err_ok_reg;
    err_rgb_t   carry_reg;
    err_rgb_t   nr0_reg;
    err_rgb_t   nr1_reg;
    logic       em_we;
    logic [COL_AW-1:0] em_addr;
    err_rgb_t   em_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.pix_take) begin
            pix_r_reg  <= s_red_in;
            pix_g_reg  <= s_green_in;
            pix_b_reg  <= s_blue_in;
            err_q_reg  <= err_mem[col_reg];
            // Entries past what the previous row wrote count as cleared.
            err_ok_reg <= 10'(col_reg) < fill_reg;
        end
        if (em_we) begin
            err_mem[em_addr] <= em_wdata;
        end
    end

    // Clamped pixel value.
    logic [23:0] val_reg;
    err_rgb_t    err_sel;
    logic signed [11:0] sum_r, sum_g, sum_b;

    always_comb begin
        err_sel = err_ok_reg ? err_q_reg : '0;
        sum_r = $signed({4'b0000, pix_r_reg}) + 12'(err_sel.r) + 12'(carry_reg.r);
        sum_g = $signed({4'b0000, pix_g_reg}) + 12'(err_sel.g) + 12'(carry_reg.g);
        sum_b = $signed({4'b0000, pix_b_reg}) + 12'(err_sel.b) + 12'(carry_reg.b);
    end

    always_ff @(posedge aclk) begin
        if (cmd.val_load) begin
            val_reg <= {clamp8(sum_r), clamp8(sum_g), clamp8(sum_b)};
        end
    end

    // Palette memory and search pipeline: read, distance, compare.
    logic [23:0]       pal_mem [PALETTE_DEPTH];
    logic [PAL_AW-1:0] sidx_reg;
    logic              issuing_reg;
    logic              issue_last;
    logic [23:0]       pal_q_reg;
    logic              v1_reg, last1_reg;
    logic [PAL_AW-1:0] idx1_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              v2_reg, last2_reg;
    logic [PAL_AW-1:0] idx2_reg;
    logic [23:0]       col2_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [PAL_AW-1:0] best_idx_reg;
    logic [23:0]       best_col_reg;
    logic              first_reg;
    logic              busy_reg;

    assign issue_last = {1'b0, sidx_reg} == (n_eff - 6'd1);

    always_ff @(posedge aclk) begin
        if (cmd.pal_wr && (int'(s_entry_index) < PALETTE_DEPTH)) begin
            pal_mem[s_entry_index[PAL_AW-1:0]] <= {s_red_in, s_green_in, s_blue_in};
        end
        pal_q_reg <= pal_mem[sidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            busy_reg    <= 1'b0;
            first_reg   <= 1'b0;
            sidx_reg    <= '0;
        end else begin
            v1_reg <= issuing_reg;
            v2_reg <= v1_reg;
            if (cmd.search_start) begin
                sidx_reg    <= '0;
                issuing_reg <= 1'b1;
                busy_reg    <= 1'b1;
                first_reg   <= 1'b1;
            end else if (issuing_reg) begin
                sidx_reg <= sidx_reg + 1'b1;
                if (issue_last) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (v2_reg) begin
                first_reg <= 1'b0;
                if (last2_reg) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        last1_reg <= issue_last;
        idx1_reg  <= sidx_reg;
        last2_reg <= last1_reg;
        idx2_reg  <= idx1_reg;
        col2_reg  <= pal_q_reg;
        dist_reg  <= DIST_W'(sq9(pal_q_reg[23:16], val_reg[23:16]))
                   + DIST_W'(sq9(pal_q_reg[15:8],  val_reg[15:8]))
                   + DIST_W'(sq9(pal_q_reg[7:0],   val_reg[7:0]));
        if (v2_reg && (first_reg || (dist_reg < best_dist_reg))) begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= idx2_reg;
            best_col_reg  <= col2_reg;
        end
    end

    // Error diffusion. The right share rides in carry_reg to the next pixel;
    // the three lower shares build up in a two-entry window and each
    // next-row entry is written once, when no more pixels touch it.
    err_rgb_t e_rgb;
    err_rgb_t s7, s3, s5, s1;
    logic     down_en;

    always_comb begin
        e_rgb   = rgb_err(val_reg, best_col_reg);
        down_en = de_reg && !last_row;
        s7 = rgb_share(e_rgb, 4'd7, de_reg && !last_col);
        s3 = rgb_share(e_rgb, 4'd3, down_en);
        s5 = rgb_share(e_rgb, 4'd5, down_en);
        s1 = rgb_share(e_rgb, 4'd1, down_en && !last_col);
        em_we    = (cmd.commit && (col_reg != '0)) || (cmd.finish && last_col);
        em_addr  = cmd.commit ? col_reg - 1'b1 : col_reg;
        em_wdata = cmd.commit ? rgb_add(nr1_reg, s3) : nr1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
            nr0_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            if (cmd.commit) begin
                carry_reg <= s7;
                nr0_reg   <= s1;
            end
            if (cmd.finish) begin
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg  <= '0;
                        fill_reg <= '0;
                    end else begin
                        row_reg  <= row_reg + 1'b1;
                        fill_reg <= 10'(col_reg) + 10'd1;
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            nr1_reg <= rgb_add(nr0_reg, s5);
        end
    end

    // Output register.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_color_index <= best_idx_reg;
            m_red_out     <= best_col_reg[23:16];
            m_green_out   <= best_col_reg[15:8];
            m_blue_out    <= best_col_reg[7:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign sts.search_busy = busy_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result committed over an untaken transaction");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_start |-> !busy_reg)
        else $error("search restarted while running");
    a_search_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && last2_reg && !cmd.search_start) |=> !busy_reg)
        else $error("search did not finish after its last entry");
`endif

endmodule

// File: sv/palette_quantize_error_diffusion_rgb_top.sv
// ----------------------------------------------------------------------------
// palette_quantize_error_diffusion_rgb_top
// Nearest-palette RGB quantizer with Floyd-Steinberg error diffusion.
// ----------------------------------------------------------------------------
// Input channel (s_*): each transaction is a palette load (opcode 0) or a
// raster-order pixel (opcode 1). A palette load is written as it is taken and
// gives no result. A pixel gives one result on the m_* channel: the chosen
// palette index and its color.
// Configuration (cfg_*): register writes are always taken; the user must make
// them only while no pixel is in progress, as the block does not enforce this.
// Search: the entries searched are palette_size limited to 1..32, read one
// palette entry per cycle through a three-stage read/distance/compare pipe.
// A pixel's result is registered at its commit step, and the next
// transaction is taken after the counter update that follows it.
// Reset: the error line is empty, counters return to the first pixel of a
// frame, configuration takes its defaults; palette contents are unknown
// until loaded.
// Stall: a result waits in the output register; a following pixel is taken
// and searched, and holds at its commit step until the result is taken.
// ----------------------------------------------------------------------------
module palette_quantize_error_diffusion_rgb_top
    import pqed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [4:0]  s_entry_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_color_index,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out
);

    pqed_cmd_t cmd;
    pqed_sts_t sts;

    pqed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pqed_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .s_entry_index (s_entry_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out)
    );

endmodule
